/* sv/btpc_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btpc_pkg
// Shared types and constants for the barometer compensation core: channel
// payloads, calibration register indexes and datapath widths.
// ----------------------------------------------------------------------------
package btpc_pkg;

	localparam int RAW_W  = 24;
	localparam int CAL_W  = 16;
	localparam int TEMP_W = 19;
	localparam int PRES_W = 20;
	localparam int IDX_W  = 3;

	localparam int NSTAGE = 8;

	localparam logic signed [TEMP_W-1:0] TEMP_REF = 19'sd2000;
	localparam logic [PRES_W-1:0]        PRES_MAX = 20'd1048575;

	typedef enum logic [IDX_W-1:0] {
		REG_PRESSURE_SENSITIVITY  = 3'd0,
		REG_PRESSURE_OFFSET       = 3'd1,
		REG_SENS_TEMP_COEFF       = 3'd2,
		REG_OFFSET_TEMP_COEFF     = 3'd3,
		REG_REFERENCE_TEMPERATURE = 3'd4,
		REG_TEMP_SLOPE            = 3'd5
	} cfg_reg_t;

	typedef struct packed {
		logic [RAW_W-1:0] raw_pressure;
		logic [RAW_W-1:0] raw_temperature;
	} btpc_in_t;

	typedef struct packed {
		logic signed [TEMP_W-1:0] temperature_centi;
		logic [PRES_W-1:0]        pressure_pa;
		logic                     low_temp_corrected;
	} btpc_out_t;

endpackage
`default_nettype wire

/* sv/btpc_ifs.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// btpc channel interfaces
// Valid/ready channels for raw conversion pairs and compensated results.
// ----------------------------------------------------------------------------
interface btpc_in_if import btpc_pkg::*; ();
	logic     valid;
	logic     ready;
	btpc_in_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface

interface btpc_out_if import btpc_pkg::*; ();
	logic      valid;
	logic      ready;
	btpc_out_t data;

	modport source(output valid, output data, input ready);
	modport sink(input valid, input data, output ready);
endinterface
`default_nettype wire

/* sv/baro_temp_pressure_compensation_core.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// baro_temp_pressure_compensation_core
// Second-order temperature and pressure compensation of a raw barometer
// conversion pair against six calibration words.
// ----------------------------------------------------------------------------
//  channel  direction  handshake     payload
//  sample   in         valid/ready   raw_pressure, raw_temperature
//  result   out        valid/ready   temperature_centi, pressure_pa,
//                                    low_temp_corrected
//  cfg      in         cfg_we        cfg_index, cfg_wdata (16 bits)
//
// One item per cycle while the result is not stalled; result valid rises once the item
// has passed all 8 stage registers, the first loaded at the accepting edge.
// Depth is set by the chain of dependent multiplies: dT products, the
// (2000-TEMP)^2 square, and the split raw_pressure * SENS product.
// arst_n clears the stage valid bits and the calibration registers.
// Each stage advances when it is empty or its successor advances, so
// bubbles close up under a stalled result and no item is lost or repeated.
// ----------------------------------------------------------------------------
module baro_temp_pressure_compensation_core import btpc_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             cfg_we,
	input  wire logic [IDX_W-1:0] cfg_index,
	input  wire logic [CAL_W-1:0] cfg_wdata,
	btpc_in_if.sink               sample,
	btpc_out_if.source            result
);

	// calibration words
	logic [CAL_W-1:0] pressure_sensitivity_q;
	logic [CAL_W-1:0] pressure_offset_q;
	logic [CAL_W-1:0] sens_temp_coeff_q;
	logic [CAL_W-1:0] offset_temp_coeff_q;
	logic [CAL_W-1:0] reference_temperature_q;
	logic [CAL_W-1:0] temp_slope_q;

	logic [NSTAGE:1] stage_valid_q;
	logic [NSTAGE:1] adv;

	// stage payloads
	logic signed [24:0]       dt_s1;
	logic [RAW_W-1:0]         d1_s1, d1_s2, d1_s3, d1_s4, d1_s5;
	logic signed [41:0]       p_slope_s2, p_off_s2, p_sens_s2;
	logic [47:0]              dtsq_s2;
	logic signed [TEMP_W-1:0] temp_s3, temp_s4, temp_s5, temp_s6, temp_s7, temp_s8;
	logic                     low_s3, low_s4, low_s5, low_s6, low_s7, low_s8;
	logic signed [35:0]       off_s3, off_s4;
	logic signed [34:0]       sens_s3, sens_s4;
	logic [16:0]              t2_s3, t2_s4;
	logic [35:0]              x_s4;
	logic signed [39:0]       off_s5, off_s6, off_s7;
	logic signed [38:0]       sens_s5;
	logic [43:0]              plo_s6;
	logic signed [43:0]       phi_s6;
	logic signed [42:0]       q1_s7;
	logic [PRES_W-1:0]        pres_s8;

	// combinational per stage
	logic signed [24:0]       dt_c;
	logic signed [49:0]       dtsq_c;
	logic signed [41:0]       adj_slope, adj_off, adj_sens;
	logic signed [34:0]       qo_c;
	logic signed [33:0]       qs_c;
	logic signed [TEMP_W-1:0] temp_c;
	logic signed [TEMP_W-1:0] diff_c;
	logic [17:0]              diff_u;
	logic [38:0]              five_x;
	logic signed [19:0]       temp_corr;
	logic signed [63:0]       prod_c, adj_prod;
	logic signed [43:0]       v_c, adj_v;
	logic signed [28:0]       p_c;
	logic [PRES_W-1:0]        pres_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pressure_sensitivity_q  <= '0;
			pressure_offset_q       <= '0;
			sens_temp_coeff_q       <= '0;
			offset_temp_coeff_q     <= '0;
			reference_temperature_q <= '0;
			temp_slope_q            <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_PRESSURE_SENSITIVITY:  pressure_sensitivity_q  <= cfg_wdata;
				REG_PRESSURE_OFFSET:       pressure_offset_q       <= cfg_wdata;
				REG_SENS_TEMP_COEFF:       sens_temp_coeff_q       <= cfg_wdata;
				REG_OFFSET_TEMP_COEFF:     offset_temp_coeff_q     <= cfg_wdata;
				REG_REFERENCE_TEMPERATURE: reference_temperature_q <= cfg_wdata;
				REG_TEMP_SLOPE:            temp_slope_q            <= cfg_wdata;
				default: ;
			endcase
		end
	end

	// stage advance: move when empty or when the next stage moves
	always_comb begin
		adv[NSTAGE] = !stage_valid_q[NSTAGE] || result.ready;
		for (int k = NSTAGE - 1; k >= 1; k--) begin
			adv[k] = !stage_valid_q[k] || adv[k+1];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stage_valid_q <= '0;
		end else begin
			if (adv[1]) begin
				stage_valid_q[1] <= sample.valid;
			end
			for (int k = 2; k <= NSTAGE; k++) begin
				if (adv[k]) begin
					stage_valid_q[k] <= stage_valid_q[k-1];
				end
			end
		end
	end

	assign sample.ready = adv[1];
	assign result.valid = stage_valid_q[NSTAGE];
	assign result.data  = {temp_s8, pres_s8, low_s8};

	always_comb begin
		// dT = D2 - C5 * 256
		dt_c = $signed({1'b0, sample.data.raw_temperature})
			- $signed({1'b0, reference_temperature_q, 8'd0});

		dtsq_c = dt_s1 * dt_s1;

		// truncate toward zero: bias negative values before the shift
		adj_slope = p_slope_s2 + $signed({19'd0, {23{p_slope_s2[41]}}});
		adj_off   = p_off_s2 + $signed({35'd0, {7{p_off_s2[41]}}});
		adj_sens  = p_sens_s2 + $signed({34'd0, {8{p_sens_s2[41]}}});
		qo_c      = adj_off[41:7];
		qs_c      = adj_sens[41:8];
		temp_c    = TEMP_REF + $signed(adj_slope[41:23]);

		diff_c = TEMP_REF - temp_s3;
		diff_u = low_s3 ? diff_c[17:0] : 18'd0;

		five_x    = {1'b0, x_s4, 2'b00} + {3'b000, x_s4};
		temp_corr = 20'(temp_s4) - $signed({3'b000, (low_s4 ? t2_s4 : 17'd0)});

		prod_c   = (64'(phi_s6) <<< 20) + $signed({20'd0, plo_s6});
		adj_prod = prod_c + $signed({43'd0, {21{prod_c[63]}}});

		v_c   = 44'(q1_s7) - 44'(off_s7);
		adj_v = v_c + $signed({29'd0, {15{v_c[43]}}});
		p_c   = adj_v[43:15];
		priority if (p_c[28]) begin
			pres_c = '0;
		end else if (|p_c[27:20]) begin
			pres_c = PRES_MAX;
		end else begin
			pres_c = p_c[19:0];
		end
	end

	always_ff @(posedge clk) begin
		if (adv[1]) begin
			dt_s1 <= dt_c;
			d1_s1 <= sample.data.raw_pressure;
		end
		// dT products
		if (adv[2]) begin
			p_slope_s2 <= dt_s1 * $signed({1'b0, temp_slope_q});
			p_off_s2   <= dt_s1 * $signed({1'b0, offset_temp_coeff_q});
			p_sens_s2  <= dt_s1 * $signed({1'b0, sens_temp_coeff_q});
			dtsq_s2    <= dtsq_c[47:0];
			d1_s2      <= d1_s1;
		end
		// first-order TEMP, OFF, SENS
		if (adv[3]) begin
			temp_s3 <= temp_c;
			low_s3  <= temp_c < TEMP_REF;
			off_s3  <= $signed({4'd0, pressure_offset_q, 16'd0}) + 36'(qo_c);
			sens_s3 <= $signed({4'd0, pressure_sensitivity_q, 15'd0}) + 35'(qs_c);
			t2_s3   <= dtsq_s2[47:31];
			d1_s3   <= d1_s2;
		end
		// x = (2000 - TEMP)^2, zero above the threshold
		if (adv[4]) begin
			x_s4    <= 36'(diff_u) * 36'(diff_u);
			temp_s4 <= temp_s3;
			low_s4  <= low_s3;
			off_s4  <= off_s3;
			sens_s4 <= sens_s3;
			t2_s4   <= t2_s3;
			d1_s4   <= d1_s3;
		end
		// second-order correction
		if (adv[5]) begin
			off_s5  <= 40'(off_s4) - $signed({2'b00, five_x[38:1]});
			sens_s5 <= 39'(sens_s4) - $signed({2'b00, five_x[38:2]});
			temp_s5 <= temp_corr[TEMP_W-1:0];
			low_s5  <= low_s4;
			d1_s5   <= d1_s4;
		end
		// D1 * SENS as two partial products
		if (adv[6]) begin
			plo_s6  <= 44'(d1_s5) * 44'(sens_s5[19:0]);
			phi_s6  <= $signed({1'b0, d1_s5}) * $signed(sens_s5[38:20]);
			off_s6  <= off_s5;
			temp_s6 <= temp_s5;
			low_s6  <= low_s5;
		end
		if (adv[7]) begin
			q1_s7   <= adj_prod[63:21];
			off_s7  <= off_s6;
			temp_s7 <= temp_s6;
			low_s7  <= low_s6;
		end
		if (adv[8]) begin
			pres_s8 <= pres_c;
			temp_s8 <= temp_s7;
			low_s8  <= low_s7;
		end
	end

`ifndef SYNTH
	a_low_flag_cold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.data.low_temp_corrected
		|-> result.data.temperature_centi < TEMP_REF)
		else $error("correction flagged on a result at or above 20.00 C");

	a_no_flag_warm: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.data.low_temp_corrected
		|-> result.data.temperature_centi >= TEMP_REF)
		else $error("result below 20.00 C without correction");

	a_stall_only_full: assert property (@(posedge clk) disable iff (!arst_n)
		!sample.ready |-> (&stage_valid_q))
		else $error("input stalled while the pipeline has a bubble");

	a_count_grows: assert property (@(posedge clk) disable iff (!arst_n)
		(sample.valid && sample.ready) && !(result.valid && result.ready)
		|=> $countones(stage_valid_q) == $past($countones(stage_valid_q)) + 1)
		else $error("accepted item not tracked in the pipeline");

	a_count_drops: assert property (@(posedge clk) disable iff (!arst_n)
		!(sample.valid && sample.ready) && (result.valid && result.ready)
		|=> $countones(stage_valid_q) + 1 == $past($countones(stage_valid_q)))
		else $error("delivered item not removed from the pipeline");
`endif

endmodule
`default_nettype wire

/* tb/tb.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for baro_temp_pressure_compensation_core. A scoreboard
// predicts compensated temperature, pressure and the low-temperature flag
// from the calibration words and each accepted raw pair. Directed pairs hit
// the field extremes, the 20.00 degree boundary, deep cold and pressure
// clamping. Random pairs then run under a series of calibration sets, with
// random gaps on both channels.
// ----------------------------------------------------------------------------
module tb;
	import btpc_pkg::*;

	localparam int N_CAL       = REG_TEMP_SLOPE + 1;
	localparam int RAW_MAX     = (1 << RAW_W) - 1;
	localparam bit [CAL_W-1:0] CAL_MAX = '1;
	// Longest correct quiet stretch is a send gap, the pipeline and a result
	// stall, plus a calibration load: QUIET_LIMIT sits far above it.
	localparam int QUIET_LIMIT = 2000;

	// Indexes past the last calibration word: writes there must change nothing.
	localparam logic [IDX_W-1:0] IDX_SPARE_LO = 3'd6;
	localparam logic [IDX_W-1:0] IDX_SPARE_HI = 3'd7;

	localparam longint TWO_POW_15 = 64'sd32768;
	localparam longint TWO_POW_21 = 64'sd2097152;
	localparam longint TWO_POW_23 = 64'sd8388608;
	localparam longint TWO_POW_31 = 64'sd2147483648;

	typedef bit [CAL_W-1:0] cal_set_t [N_CAL];

	class btpc_scoreboard;
		bit [CAL_W-1:0] cal [N_CAL];
		btpc_out_t      expected_q [$];
		int             errors;

		function new();
			foreach (cal[i]) cal[i] = '0;
			errors = 0;
		endfunction

		function void write_cal(logic [IDX_W-1:0] idx, bit [CAL_W-1:0] v);
			if (idx <= REG_TEMP_SLOPE)
				cal[idx] = v;
		endfunction

		function btpc_out_t compensate(btpc_in_t s);
			longint    pres, dt, temp, off, sens, gap, sq, p;
			bit        cold;
			btpc_out_t r;
			pres = longint'(s.raw_pressure);
			dt   = longint'(s.raw_temperature)
			     - longint'(cal[REG_REFERENCE_TEMPERATURE]) * 256;
			temp = longint'(TEMP_REF) + dt * longint'(cal[REG_TEMP_SLOPE]) / TWO_POW_23;
			off  = longint'(cal[REG_PRESSURE_OFFSET]) * 65536
			     + longint'(cal[REG_OFFSET_TEMP_COEFF]) * dt / 128;
			sens = longint'(cal[REG_PRESSURE_SENSITIVITY]) * 32768
			     + longint'(cal[REG_SENS_TEMP_COEFF]) * dt / 256;
			cold = temp < longint'(TEMP_REF);
			if (cold) begin
				// square of the distance below 20.00 degrees, before TEMP moves
				gap  = longint'(TEMP_REF) - temp;
				sq   = gap * gap;
				temp = temp - dt * dt / TWO_POW_31;
				off  = off - 5 * sq / 2;
				sens = sens - 5 * sq / 4;
			end
			p = (pres * sens / TWO_POW_21 - off) / TWO_POW_15;
			if (p < 0)
				p = 0;
			else if (p > longint'(PRES_MAX))
				p = longint'(PRES_MAX);
			r.temperature_centi  = temp[TEMP_W-1:0];
			r.pressure_pa        = p[PRES_W-1:0];
			r.low_temp_corrected = cold;
			return r;
		endfunction

		function void note_sample(btpc_in_t s);
			expected_q.push_back(compensate(s));
		endfunction

		function void check_result(btpc_out_t got);
			btpc_out_t want;
			if (expected_q.size() == 0) begin
				$display("%0t: result with none expected: temp %0d pres %0d low %0b",
					$time, got.temperature_centi, got.pressure_pa,
					got.low_temp_corrected);
				errors++;
				return;
			end
			want = expected_q.pop_front();
			if (got.temperature_centi !== want.temperature_centi) begin
				$display("%0t: temperature_centi expected %0d actual %0d", $time,
					want.temperature_centi, got.temperature_centi);
				errors++;
			end
			if (got.pressure_pa !== want.pressure_pa) begin
				$display("%0t: pressure_pa expected %0d actual %0d", $time,
					want.pressure_pa, got.pressure_pa);
				errors++;
			end
			if (got.low_temp_corrected !== want.low_temp_corrected) begin
				$display("%0t: low_temp_corrected expected %0b actual %0b", $time,
					want.low_temp_corrected, got.low_temp_corrected);
				errors++;
			end
		endfunction

		function int pending();
			return expected_q.size();
		endfunction
	endclass

	logic             clk;
	logic             arst_n;
	logic             cfg_we;
	logic [IDX_W-1:0] cfg_index;
	logic [CAL_W-1:0] cfg_wdata;

	btpc_in_if  smp ();
	btpc_out_if res ();

	btpc_scoreboard sb = new();

	bit calm_in;
	bit calm_out;
	int quiet;

	baro_temp_pressure_compensation_core u_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.sample    (smp),
		.result    (res)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// Random gaps before each item, with occasional stretches of none at all.
	function automatic int draw_gap(inout bit calm);
		if ($urandom_range(0, 47) == 0)
			calm = ~calm;
		return calm ? 0 : int'($urandom_range(0, 7));
	endfunction

	task automatic load_cal(input cal_set_t v);
		cfg_reg_t r;
		r = REG_PRESSURE_SENSITIVITY;
		do begin
			cfg_we    <= 1'b1;
			cfg_index <= r;
			cfg_wdata <= v[r];
			sb.write_cal(r, v[r]);
			@(posedge clk);
			r = r.next();
		end while (r != REG_PRESSURE_SENSITIVITY);
		cfg_index <= $urandom_range(0, 1) ? IDX_SPARE_HI : IDX_SPARE_LO;
		cfg_wdata <= CAL_W'($urandom_range(0, CAL_MAX));
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic send_sample(input logic [RAW_W-1:0] pres, input logic [RAW_W-1:0] temp);
		int gap;
		gap = draw_gap(calm_in);
		if (gap > 0) begin
			smp.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		smp.valid                <= 1'b1;
		smp.data.raw_pressure    <= pres;
		smp.data.raw_temperature <= temp;
		do @(posedge clk); while (smp.ready !== 1'b1);
	endtask

	// Drop valid so the last item is not sent again, then wait for results.
	task automatic drain();
		smp.valid <= 1'b0;
		while (sb.pending() != 0)
			@(posedge clk);
	endtask

	task automatic run_random(input int n);
		longint      t;
		int unsigned p;
		int unsigned span;
		for (int k = 0; k < n; k++) begin
			p = $urandom_range(0, RAW_MAX);
			case ($urandom_range(0, 9))
				0, 1, 2, 3, 4, 5: begin
					// raw temperature near the reference, both sides of 20.00
					span = 1 << $urandom_range(2, 21);
					t = longint'(sb.cal[REG_REFERENCE_TEMPERATURE]) * 256
					  + longint'($urandom_range(0, 2 * span)) - longint'(span);
					if (t < 0)
						t = 0;
					else if (t > RAW_MAX)
						t = RAW_MAX;
				end
				6, 7, 8: t = $urandom_range(0, RAW_MAX);
				default: begin
					p = $urandom_range(0, 1) ? RAW_MAX : 0;
					t = $urandom_range(0, 1) ? RAW_MAX : 0;
				end
			endcase
			send_sample(p[RAW_W-1:0], t[RAW_W-1:0]);
		end
	endtask

	// Sample at the falling edge: handshake signals are stable there.
	always @(negedge clk) begin
		if (smp.valid === 1'b1 && smp.ready === 1'b1)
			sb.note_sample(smp.data);
		if (res.valid === 1'b1 && res.ready === 1'b1)
			sb.check_result(res.data);
		if ((smp.valid === 1'b1 && smp.ready === 1'b1)
				|| (res.valid === 1'b1 && res.ready === 1'b1)) begin
			quiet = 0;
		end else begin
			quiet++;
			if (quiet >= QUIET_LIMIT) begin
				$display("Mismatches found");
				$finish;
			end
		end
	end

	initial begin
		int gap;
		res.ready <= 1'b0;
		do @(posedge clk); while (arst_n !== 1'b1);
		forever begin
			gap = draw_gap(calm_out);
			if (gap > 0) begin
				res.ready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			res.ready <= 1'b1;
			do @(posedge clk); while (res.valid !== 1'b1);
		end
	end

	initial begin
		cal_set_t    cal;
		int unsigned ref_raw;
		int unsigned step;
		quiet     = 0;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_index <= '0;
		cfg_wdata <= '0;
		smp.valid <= 1'b0;
		smp.data  <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// typical factory words, in register order
		cal = '{40127, 36924, 23317, 23282, 33464, 28312};
		load_cal(cal);
		ref_raw = 33464 * 256;
		// smallest drop below the reference that takes TEMP to 19.99
		step = (8388608 + 28312 - 1) / 28312;
		send_sample(0, 0);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(0, RAW_MAX);
		send_sample(RAW_MAX, 0);
		send_sample(9085466, ref_raw);
		send_sample(9085466, ref_raw - step);
		send_sample(9085466, ref_raw - step + 1);
		send_sample(9085466, 8569854);
		send_sample(9085466, 8000000);
		send_sample(1, ref_raw);
		drain();

		// all words at full scale: raw temperature 0 is deep cold
		foreach (cal[i]) cal[i] = CAL_MAX;
		load_cal(cal);
		send_sample(0, 0);
		send_sample(RAW_MAX, 0);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(0, RAW_MAX);
		drain();

		// high sensitivity and no offset: clamp at the top of the range
		cal = '{CAL_MAX, 0, CAL_MAX, 0, 0, 0};
		load_cal(cal);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(RAW_MAX, 0);
		drain();

		foreach (cal[i]) cal[i] = '0;
		load_cal(cal);
		send_sample(RAW_MAX, RAW_MAX);
		send_sample(0, 0);
		send_sample(RAW_MAX, 0);
		drain();

		for (int ph = 0; ph < 8; ph++) begin
			foreach (cal[i]) begin
				case ($urandom_range(0, 7))
					0:       cal[i] = '0;
					1:       cal[i] = CAL_MAX;
					default: cal[i] = CAL_W'($urandom_range(0, CAL_MAX));
				endcase
			end
			load_cal(cal);
			run_random(200);
			drain();
		end

		repeat (NSTAGE + 2) @(posedge clk);
		if (sb.errors == 0 && sb.pending() == 0)
			$display("No mismatches found");
		else
			$display("Mismatches found");
		$finish;
	end

endmodule
`default_nettype wire
